[src/tlsa_pkg.sv]
// ----------------------------------------------------------------------------
// tlsa_pkg
// Shared constants, types and the saturating add for the trigram score core.
// ----------------------------------------------------------------------------
package tlsa_pkg;

    localparam int TableDepth = 17576;
    localparam int AddrW      = 15;
    localparam int EntryW     = 16;
    localparam int ScoreW     = 28;
    localparam int ByteW      = 8;
    localparam int CodeW      = 5;

    localparam int RowStride  = 676;
    localparam int ColStride  = 26;
    localparam int LetterLast = 25;
    localparam logic [ByteW-1:0] LetterBase = 8'd65;

    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = 2;
    localparam int QueueCntW  = 3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_SCORE = 1'b1;

    localparam logic signed [ScoreW-1:0] SumHigh = 28'sd134213632;
    localparam logic signed [ScoreW:0]   SumHighWide = 29'sd134213632;
    localparam logic signed [ScoreW:0]   SumLowWide  = -29'sd134217728;

    // one command handed from the front part to the back part
    typedef struct packed {
        logic              is_write;
        logic              do_add;
        logic              last;
        logic [AddrW-1:0]  addr;
        logic [EntryW-1:0] wdata;
    } t_cmd;

    // saturating sum of the running score and one table entry
    function automatic logic signed [ScoreW-1:0] sat_add(
        input logic signed [ScoreW-1:0] sum,
        input logic signed [EntryW-1:0] entry
    );
        logic signed [ScoreW:0] w_sum;
        logic signed [ScoreW:0] w_res;
        w_sum = $signed({sum[ScoreW-1], sum}) +
                $signed({{(ScoreW+1-EntryW){entry[EntryW-1]}}, entry});
        if (w_sum > SumHighWide) begin
            w_res = SumHighWide;
        end else if (w_sum < SumLowWide) begin
            w_res = SumLowWide;
        end else begin
            w_res = w_sum;
        end
        return w_res[ScoreW-1:0];
    endfunction

endpackage

[src/trigram_log_score_accumulator_core.sv]
// ----------------------------------------------------------------------------
// trigram_log_score_accumulator_core
// Scores text by summing trigram log probabilities from a loadable table.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready): one transaction per item. With
// i_opcode write it stores i_entry_value at i_entry_index in the 17576-entry
// Q8.8 table (indexes past the table are dropped). With i_opcode score it
// feeds one text byte; i_end_of_text marks the last byte of a text.
// Output channel (o_out_valid / i_out_ready): one transaction per finished
// text carrying the saturated Q20.8 score in o_text_score.
// Throughput is one item per cycle while o_in_ready is high; the single table
// port does one write or one read each cycle. o_out_valid rises once the last
// text byte passes the queue, table read and accumulate, and output register.
// A four-entry command queue lets input keep flowing while the output stalls;
// once a finished score waits and the queue fills, o_in_ready drops.
// Reset clears the letter window, the sum, the queue and the output register;
// the table keeps no reset value, so every entry must be written before any
// text is scored.
// ----------------------------------------------------------------------------
module trigram_log_score_accumulator_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_opcode,
    input  logic [tlsa_pkg::ByteW-1:0]          i_text_byte,
    input  logic                                i_end_of_text,
    input  logic [tlsa_pkg::AddrW-1:0]          i_entry_index,
    input  logic signed [tlsa_pkg::EntryW-1:0]  i_entry_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [tlsa_pkg::ScoreW-1:0]  o_text_score
);

    logic           w_push;
    logic           w_pop;
    logic           w_full;
    logic           w_empty;
    tlsa_pkg::t_cmd w_cmd;
    tlsa_pkg::t_cmd w_head;

    tlsa_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_q_full      (w_full),
        .o_push        (w_push),
        .o_cmd         (w_cmd)
    );

    tlsa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    tlsa_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (w_empty),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_text_score (o_text_score)
    );

endmodule

[src/tlsa_ram.sv]
// ----------------------------------------------------------------------------
// tlsa_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module tlsa_ram #(
    parameter int Width = 16,
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/tlsa_front.sv]
// ----------------------------------------------------------------------------
// tlsa_front
// Accepts items, keeps the two-letter window and builds table commands.
// ----------------------------------------------------------------------------
module tlsa_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_opcode,
    input  logic [tlsa_pkg::ByteW-1:0]          i_text_byte,
    input  logic                                i_end_of_text,
    input  logic [tlsa_pkg::AddrW-1:0]          i_entry_index,
    input  logic signed [tlsa_pkg::EntryW-1:0]  i_entry_value,
    input  logic                                i_q_full,
    output logic                                o_push,
    output tlsa_pkg::t_cmd                      o_cmd
);

    logic                          r_older_ok;
    logic [tlsa_pkg::CodeW-1:0]    r_older_code;
    logic                          r_newer_ok;
    logic [tlsa_pkg::CodeW-1:0]    r_newer_code;
    logic [1:0]                    r_seen;

    logic                          w_accept;
    logic                          w_score;
    logic [tlsa_pkg::ByteW-1:0]    w_code;
    logic                          w_is_letter;
    logic                          w_in_range;
    logic [tlsa_pkg::AddrW-1:0]    w_index;

    assign o_in_ready  = !i_q_full;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_score     = (i_opcode == tlsa_pkg::OP_SCORE);
    assign w_code      = i_text_byte - tlsa_pkg::LetterBase;
    assign w_is_letter = (w_code <= 8'(tlsa_pkg::LetterLast));
    assign w_in_range  = (i_entry_index < 15'(tlsa_pkg::TableDepth));

    assign w_index = 15'(r_older_code) * 15'(tlsa_pkg::RowStride)
                   + 15'(r_newer_code) * 15'(tlsa_pkg::ColStride)
                   + 15'(w_code[tlsa_pkg::CodeW-1:0]);

    always_comb begin
        o_cmd.is_write = !w_score;
        o_cmd.do_add   = w_score && (r_seen == 2'd2) && r_older_ok && r_newer_ok
                         && w_is_letter;
        o_cmd.last     = w_score && i_end_of_text;
        o_cmd.addr     = w_score ? w_index : i_entry_index;
        o_cmd.wdata    = i_entry_value;
    end

    // out-of-range table writes are taken and dropped
    assign o_push = w_accept && (w_score || w_in_range);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older_ok   <= 1'b0;
            r_older_code <= '0;
            r_newer_ok   <= 1'b0;
            r_newer_code <= '0;
            r_seen       <= 2'd0;
        end else if (w_accept && w_score) begin
            if (i_end_of_text) begin
                r_older_ok   <= 1'b0;
                r_older_code <= '0;
                r_newer_ok   <= 1'b0;
                r_newer_code <= '0;
                r_seen       <= 2'd0;
            end else begin
                r_older_ok   <= r_newer_ok;
                r_older_code <= r_newer_code;
                r_newer_ok   <= w_is_letter;
                r_newer_code <= w_code[tlsa_pkg::CodeW-1:0];
                if (r_seen != 2'd2) begin
                    r_seen <= r_seen + 2'd1;
                end
            end
        end
    end

endmodule

[src/tlsa_queue.sv]
// ----------------------------------------------------------------------------
// tlsa_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module tlsa_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tlsa_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output tlsa_pkg::t_cmd o_head
);

    tlsa_pkg::t_cmd                  r_slot [tlsa_pkg::QueueDepth];
    logic [tlsa_pkg::QueuePtrW-1:0]  r_wr_ptr;
    logic [tlsa_pkg::QueuePtrW-1:0]  r_rd_ptr;
    logic [tlsa_pkg::QueueCntW-1:0]  r_count;
    logic [tlsa_pkg::QueueCntW-1:0]  n_count;

    assign o_full  = (r_count == 3'(tlsa_pkg::QueueDepth));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 3'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 2'd1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= n_count;
        end
    end

endmodule

[src/tlsa_back.sv]
// ----------------------------------------------------------------------------
// tlsa_back
// Executes queued commands on the table and accumulates the text score.
// ----------------------------------------------------------------------------
module tlsa_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_empty,
    input  tlsa_pkg::t_cmd                      i_head,
    output logic                                o_pop,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [tlsa_pkg::ScoreW-1:0]  o_text_score
);

    logic                                 r_s1_vld;
    logic                                 r_s1_add;
    logic                                 r_s1_last;
    logic signed [tlsa_pkg::ScoreW-1:0]   r_sum;
    logic                                 r_out_vld;
    logic signed [tlsa_pkg::ScoreW-1:0]   r_out_score;

    logic                                 w_advance;
    logic                                 w_issue;
    logic [tlsa_pkg::EntryW-1:0]          w_rdata;
    logic signed [tlsa_pkg::ScoreW-1:0]   n_sum;

    // hold the accumulate stage only when a finished score cannot be handed on
    assign w_advance = !(r_s1_vld && r_s1_last && r_out_vld && !i_out_ready);
    assign w_issue   = w_advance && !i_q_empty;
    assign o_pop     = w_issue;

    tlsa_ram #(
        .Width (tlsa_pkg::EntryW),
        .Depth (tlsa_pkg::TableDepth)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_issue && i_head.is_write),
        .i_re    (w_issue && !i_head.is_write && i_head.do_add),
        .i_addr  (i_head.addr),
        .i_wdata (i_head.wdata),
        .o_rdata (w_rdata)
    );

    assign n_sum = r_s1_add ? tlsa_pkg::sat_add(r_sum, $signed(w_rdata)) : r_sum;

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_s1_add  <= i_head.do_add;
            r_s1_last <= i_head.last;
        end
        if (r_s1_vld && w_advance && r_s1_last) begin
            r_out_score <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_sum     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_advance) begin
                r_s1_vld <= w_issue && !i_head.is_write;
            end
            if (r_s1_vld && w_advance) begin
                r_sum <= r_s1_last ? '0 : n_sum;
            end
            if (r_s1_vld && w_advance && r_s1_last) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_text_score = r_out_score;

endmodule

[src/tlsa_checker.sv]
// ----------------------------------------------------------------------------
// tlsa_checker
// Port-level checks for the trigram score core, bound to the top level.
// ----------------------------------------------------------------------------
module tlsa_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_in_ready,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic signed [tlsa_pkg::ScoreW-1:0]  o_text_score
);

    // a stalled score transaction holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_text_score))
        else $error("score changed while stalled");

    // the sum clamps below the top of the range
    a_score_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_text_score <= tlsa_pkg::SumHigh))
        else $error("score above saturation limit");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("score pending after reset");

    // queue is empty after reset, so input is open
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("input blocked after reset");

endmodule

bind trigram_log_score_accumulator_core tlsa_checker u_checker (.*);

[tb/sv/tb_trigram_log_score_accumulator_core.sv]
// ----------------------------------------------------------------------------
// tb_trigram_log_score_accumulator_core
// Loads the table entries that the texts can reach, then scores directed and
// random texts over a small letter set. Each input transaction is applied to
// a model of the window, sum and table inside a small scoreboard class. Every
// score transaction is checked against the oldest predicted score. Both
// handshakes idle at random, and the output is held off long enough that the
// input stalls.
// ----------------------------------------------------------------------------
module tb_trigram_log_score_accumulator_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCORE_MIN      = -134217728;
    localparam int SCORE_MAX      = 134213632;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 250;
    localparam int RANDOM_ITEMS   = 720;
    localparam int LONG_TEXT_LEN  = 60;
    localparam int SUBSET_SIZE    = 4;

    localparam logic [tlsa_pkg::ByteW-1:0] CHAR_A   = "A";
    localparam logic [tlsa_pkg::ByteW-1:0] CHAR_M   = "M";
    localparam logic [tlsa_pkg::ByteW-1:0] CHAR_Q   = "Q";
    localparam logic [tlsa_pkg::ByteW-1:0] CHAR_Z   = "Z";
    localparam logic [tlsa_pkg::ByteW-1:0] CHAR_AT  = "@";
    localparam logic [tlsa_pkg::ByteW-1:0] CHAR_BRK = "[";

    // texts only use these letters, so only their trigrams need loading
    function automatic logic [tlsa_pkg::ByteW-1:0] subset_letter(input int unsigned n);
        case (n)
            0: return CHAR_A;
            1: return CHAR_M;
            2: return CHAR_Q;
            default: return CHAR_Z;
        endcase
    endfunction

    function automatic int letter_code(input int unsigned n);
        return int'(subset_letter(n) - tlsa_pkg::LetterBase);
    endfunction

    class trigram_score_tracker;
        logic signed [tlsa_pkg::EntryW-1:0] log_prob [tlsa_pkg::TableDepth];
        logic [tlsa_pkg::ByteW-1:0]         older_code;
        logic [tlsa_pkg::ByteW-1:0]         newer_code;
        int unsigned                        window_fill;
        int                                 acc;
        int                                 expected_scores[$];
        int unsigned                        failures;

        function new();
            foreach (log_prob[i]) log_prob[i] = '0;
            older_code  = '0;
            newer_code  = '0;
            window_fill = 0;
            acc         = 0;
            failures    = 0;
        endfunction

        function int pending();
            return expected_scores.size();
        endfunction

        function void note_item(logic op, logic [tlsa_pkg::ByteW-1:0] text_byte, logic eot,
                                logic [tlsa_pkg::AddrW-1:0] idx,
                                logic signed [tlsa_pkg::EntryW-1:0] val);
            logic [tlsa_pkg::ByteW-1:0] code;
            int                         slot;
            if (op == tlsa_pkg::OP_WRITE) begin
                if (idx < tlsa_pkg::TableDepth) log_prob[idx] = val;
                return;
            end
            code = text_byte - tlsa_pkg::LetterBase;
            if (window_fill >= 2 && older_code <= tlsa_pkg::LetterLast &&
                newer_code <= tlsa_pkg::LetterLast && code <= tlsa_pkg::LetterLast) begin
                slot = int'(older_code) * tlsa_pkg::RowStride
                     + int'(newer_code) * tlsa_pkg::ColStride + int'(code);
                acc  = acc + int'(log_prob[slot]);
                if (acc < SCORE_MIN) acc = SCORE_MIN;
                if (acc > SCORE_MAX) acc = SCORE_MAX;
            end
            older_code = newer_code;
            newer_code = code;
            if (window_fill < 2) window_fill++;
            if (eot) begin
                expected_scores.push_back(acc);
                older_code  = '0;
                newer_code  = '0;
                window_fill = 0;
                acc         = 0;
            end
        endfunction

        function void check_score(logic signed [tlsa_pkg::ScoreW-1:0] got);
            int want;
            if (expected_scores.size() == 0) begin
                failures++;
                if (failures <= 10) $display("unexpected score transaction: got %0d", got);
                return;
            end
            want = expected_scores.pop_front();
            if (int'(got) != want) begin
                failures++;
                if (failures <= 10) $display("score mismatch: expected %0d, got %0d", want, got);
            end
        endfunction
    endclass

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_in_valid;
    logic                               o_in_ready;
    logic                               i_opcode;
    logic [tlsa_pkg::ByteW-1:0]         i_text_byte;
    logic                               i_end_of_text;
    logic [tlsa_pkg::AddrW-1:0]         i_entry_index;
    logic signed [tlsa_pkg::EntryW-1:0] i_entry_value;
    logic                               o_out_valid;
    logic                               i_out_ready;
    logic signed [tlsa_pkg::ScoreW-1:0] o_text_score;

    trigram_score_tracker tracker = new();

    bit          feed_idle_en  = 1'b1;
    bit          drain_idle_en = 1'b1;
    bit          long_hold_req = 1'b0;
    int unsigned items_sent    = 0;
    int unsigned quiet_cycles  = 0;

    trigram_log_score_accumulator_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_text_score  (o_text_score)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // one input transaction, with an optional idle burst ahead of it
    task automatic send_item(input logic op, input logic [tlsa_pkg::ByteW-1:0] text_byte,
                             input logic eot, input logic [tlsa_pkg::AddrW-1:0] idx,
                             input logic [tlsa_pkg::EntryW-1:0] val);
        if (feed_idle_en && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_text_byte   <= text_byte;
        i_end_of_text <= eot;
        i_entry_index <= idx;
        i_entry_value <= val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tracker.note_item(op, text_byte, eot, idx, val);
        items_sent++;
    endtask

    task automatic write_entry(input logic [tlsa_pkg::AddrW-1:0] idx,
                               input logic [tlsa_pkg::EntryW-1:0] val, input logic eot);
        send_item(tlsa_pkg::OP_WRITE, tlsa_pkg::ByteW'($urandom_range(0, 255)), eot, idx,
                  val);
    endtask

    task automatic send_repeated_text(input logic [tlsa_pkg::ByteW-1:0] letter,
                                      input int len);
        for (int i = 0; i < len; i++) begin
            send_item(tlsa_pkg::OP_SCORE, letter, i == len - 1,
                      tlsa_pkg::AddrW'($urandom_range(0, 32767)),
                      tlsa_pkg::EntryW'($urandom_range(0, 65535)));
        end
    endtask

    // mostly letters so trigrams hit, some raw bytes and the odd table write
    task automatic send_random_text(input int len);
        logic [tlsa_pkg::ByteW-1:0] b;
        logic [tlsa_pkg::ByteW-1:0] c;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                write_entry(tlsa_pkg::AddrW'($urandom_range(0, tlsa_pkg::TableDepth - 1)),
                            tlsa_pkg::EntryW'($urandom_range(0, 65535)),
                            1'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 7) == 0) begin
                b = tlsa_pkg::ByteW'($urandom_range(0, 255));
                c = b - tlsa_pkg::LetterBase;
                // raw bytes that land on a letter stay inside the loaded set
                if (c <= tlsa_pkg::ByteW'(tlsa_pkg::LetterLast)) begin
                    b = subset_letter($urandom_range(0, SUBSET_SIZE - 1));
                end
            end else begin
                b = subset_letter($urandom_range(0, SUBSET_SIZE - 1));
            end
            send_item(tlsa_pkg::OP_SCORE, b, i == len - 1,
                      tlsa_pkg::AddrW'($urandom_range(0, 32767)),
                      tlsa_pkg::EntryW'($urandom_range(0, 65535)));
        end
    endtask

    task automatic wait_for_scores();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    // receiver side: random stalls plus one long hold on request
    initial begin : drain_proc
        int unsigned stall_left;
        stall_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) tracker.check_score(o_text_score);
            if (long_hold_req) begin
                stall_left    = LONG_HOLD;
                long_hold_req = 1'b0;
            end else if (stall_left == 0 && drain_idle_en && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 19);
            end
            if (stall_left != 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("trigram_log_score_accumulator_core test failed");
            $finish;
        end
    end

    initial begin : feed_proc
        logic [tlsa_pkg::EntryW-1:0] seed_val;
        int                          seed_idx;
        int unsigned                 random_start;
        bit                          pressure_done;
        bit                          pause_done;
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_opcode      <= tlsa_pkg::OP_WRITE;
        i_text_byte   <= '0;
        i_end_of_text <= 1'b0;
        i_entry_index <= '0;
        i_entry_value <= '0;
        pressure_done = 1'b0;
        pause_done    = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every trigram over the letter set gets written before any text is scored
        for (int ia = 0; ia < SUBSET_SIZE; ia++) begin
            for (int ib = 0; ib < SUBSET_SIZE; ib++) begin
                for (int ic = 0; ic < SUBSET_SIZE; ic++) begin
                    seed_idx = letter_code(ia) * tlsa_pkg::RowStride
                             + letter_code(ib) * tlsa_pkg::ColStride + letter_code(ic);
                    if ($urandom_range(0, 15) == 0) begin
                        seed_val = tlsa_pkg::EntryW'($urandom_range(0, 65535));
                    end else begin
                        seed_val = -tlsa_pkg::EntryW'($urandom_range(0, 1536));
                    end
                    write_entry(tlsa_pkg::AddrW'(seed_idx), seed_val, 1'($urandom_range(0, 1)));
                end
            end
        end

        // extremes, dropped writes, short texts and non-letter bytes
        write_entry(tlsa_pkg::AddrW'(0), 16'h7FFF, 1'b1);
        write_entry(tlsa_pkg::AddrW'(tlsa_pkg::TableDepth - 1), 16'h8000, 1'b0);
        write_entry(tlsa_pkg::AddrW'(tlsa_pkg::TableDepth), 16'h1234, 1'b1);
        write_entry(15'h7FFF, 16'hFFFF, 1'b0);
        send_repeated_text(CHAR_A, 3);
        send_repeated_text(CHAR_Z, 3);
        send_repeated_text(CHAR_Q, 1);
        send_repeated_text(CHAR_M, 2);
        send_item(tlsa_pkg::OP_SCORE, CHAR_A, 1'b0, '0, '0);
        send_item(tlsa_pkg::OP_SCORE, CHAR_AT, 1'b0, '1, '1);
        send_item(tlsa_pkg::OP_SCORE, 8'h00, 1'b0, '0, '0);
        write_entry(tlsa_pkg::AddrW'(tlsa_pkg::TableDepth - 1), 16'h8000, 1'b1);
        send_item(tlsa_pkg::OP_SCORE, 8'hFF, 1'b0, '1, '1);
        send_item(tlsa_pkg::OP_SCORE, CHAR_BRK, 1'b0, '0, '0);
        send_repeated_text(CHAR_A, 3);

        // longer texts of the largest entries build big sums of both signs
        send_repeated_text(CHAR_A, LONG_TEXT_LEN);
        send_repeated_text(CHAR_Z, LONG_TEXT_LEN);

        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            if (!pressure_done && items_sent - random_start >= 240) begin
                pressure_done = 1'b1;
                feed_idle_en  = 1'b0;
                long_hold_req = 1'b1;
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (long_hold_req);
                // short texts pile up scores until the input stalls
                for (int i = 0; i < 40; i++) send_random_text($urandom_range(1, 2));
                feed_idle_en = 1'b1;
            end
            if (!pause_done && items_sent - random_start >= 450) begin
                pause_done = 1'b1;
                wait_for_scores();
            end
            if (items_sent - random_start >= 600) begin
                feed_idle_en  = 1'b0;
                drain_idle_en = 1'b0;
            end
            if ($urandom_range(0, 99) < 15) begin
                if ($urandom_range(0, 4) == 0) begin
                    write_entry(tlsa_pkg::AddrW'($urandom_range(tlsa_pkg::TableDepth, 32767)),
                                tlsa_pkg::EntryW'($urandom_range(0, 65535)),
                                1'($urandom_range(0, 1)));
                end else begin
                    write_entry(tlsa_pkg::AddrW'($urandom_range(0, tlsa_pkg::TableDepth - 1)),
                                tlsa_pkg::EntryW'($urandom_range(0, 65535)),
                                1'($urandom_range(0, 1)));
                end
            end else if ($urandom_range(0, 9) == 0) begin
                send_random_text($urandom_range(1, 2));
            end else begin
                send_random_text($urandom_range(3, 40));
            end
        end

        wait_for_scores();
        repeat (8) @(posedge i_clk);
        if (tracker.failures == 0) begin
            $display("trigram_log_score_accumulator_core test passed");
        end else begin
            $display("trigram_log_score_accumulator_core test failed");
        end
        $finish;
    end

endmodule

[files.f]
src/tlsa_pkg.sv
src/tlsa_ram.sv
src/tlsa_front.sv
src/tlsa_queue.sv
src/tlsa_back.sv
src/trigram_log_score_accumulator_core.sv
src/tlsa_checker.sv
tb/sv/tb_trigram_log_score_accumulator_core.sv
